// File: hdl/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants of the reply parser
// Event, kind and error codes, and the front-to-back work descriptor.
// ----------------------------------------------------------------------------
package rrp_pkg;

   localparam logic [1:0] EV_TEXT    = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_DONE    = 2'd2;
   localparam logic [1:0] EV_ERROR   = 2'd3;

   localparam logic [2:0] KIND_STATUS = 3'd0;
   localparam logic [2:0] KIND_ERRTXT = 3'd1;
   localparam logic [2:0] KIND_INT    = 3'd2;
   localparam logic [2:0] KIND_BULK   = 3'd3;
   localparam logic [2:0] KIND_NULL   = 3'd4;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_EMPTY   = 3'd1;
   localparam logic [2:0] ERR_TYPE    = 3'd2;
   localparam logic [2:0] ERR_NUMBER  = 3'd3;
   localparam logic [2:0] ERR_NEGLEN  = 3'd4;
   localparam logic [2:0] ERR_TOOLONG = 3'd5;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [30:0] MAX_BULK_RESET = 31'd536870912;

   // one result beat
   typedef struct packed {
      logic [1:0]  event_res;
      logic [2:0]  reply_kind;
      logic [7:0]  data_byte;
      logic [63:0] int_value;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // up to two beats caused by one input byte
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } work_type;

endpackage

// File: hdl/resp_reply_parser_unit.sv
// ----------------------------------------------------------------------------
// resp_reply_parser_unit: RESP2 reply parser (no arrays)
// Top level joining the byte classifier and the beat sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one reply byte per beat (req_in_byte).
//   rsp_ channel carries result beats: event, kind, data byte, integer
//   value, error code and a last flag on the final beat of each input byte.
//   csr_wr_en/csr_wr_data write max_bulk_length; write only while idle.
// Throughput: one input byte per cycle while req_stall is low. A byte that
//   yields results has its descriptor registered in the queue before its
//   first beat shows; a text byte following a held CR yields two beats.
// A four-entry descriptor queue sits between the classifier and the
//   output; req_stall rises when it holds three or more entries.
// Reset (synchronous) returns the parser to await a type byte, empties
//   the queue and loads max_bulk_length with 536870912.
// When rsp_stall is high the current beat holds and the queue fills.
// ----------------------------------------------------------------------------
module resp_reply_parser_unit import rrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [2:0]  rsp_reply_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [63:0] rsp_int_value,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic     accept, work_valid, full;
   work_type work;
   rsp_type  rsp;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   rrp_front u_front (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .byte_valid (accept), .byte_data (req_in_byte),
      .work_valid, .work
   );

   rrp_back u_back (
      .clock, .reset, .work_valid, .work, .full,
      .rsp_valid, .rsp_stall, .rsp
   );

   assign rsp_event_res  = rsp.event_res;
   assign rsp_reply_kind = rsp.reply_kind;
   assign rsp_data_byte  = rsp.data_byte;
   assign rsp_int_value  = rsp.int_value;
   assign rsp_error_code = rsp.error_code;
   assign rsp_last       = rsp.last;

endmodule

// File: hdl/rrp_front.sv
// ----------------------------------------------------------------------------
// rrp_front: byte classifier and reply state
// Parses one byte per cycle and emits a descriptor of zero to two beats.
// ----------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   input  logic        byte_valid,
   input  logic [7:0]  byte_data,
   output logic        work_valid,
   output work_type    work
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_LEAD    = 3'd1;
   localparam logic [2:0] PH_TEXT    = 3'd2;
   localparam logic [2:0] PH_NUM     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  kind_ff, kind_in;
   logic        cr_ff, cr_in;
   logic [63:0] acc_ff, acc_in;
   logic        minus_ff, minus_in;
   logic        digits_ff, digits_in;
   logic [2:0]  fault_ff, fault_in;
   logic [31:0] left_ff, left_in;
   logic [30:0] max_ff;

   logic        is_digit;
   logic [3:0]  digit;
   logic [63:0] acc_x10, acc_next, limit;
   logic        ovf;
   logic [2:0]  num_fault;
   logic [1:0]  n_beats;
   rsp_type     b0, b1;

   // overflow: acc*10+d > limit, checked exactly in 68 bits
   logic [67:0] prod_wide;

   always_comb begin
      is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
      digit     = 4'(byte_data - CH_ZERO);
      acc_x10   = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
      prod_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + 68'(digit);
      if (kind_ff == KIND_INT)
         limit = minus_ff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      else
         limit = minus_ff ? 64'h0000000080000000 : 64'h000000007FFFFFFF;
      ovf       = prod_wide > {4'd0, limit};
      acc_next  = acc_x10 + 64'(digit);
   end

   function automatic rsp_type mk(logic [1:0] ev, logic [2:0] k, logic [7:0] d,
                                  logic [63:0] v, logic [2:0] e);
      rsp_type r;
      r.event_res = ev; r.reply_kind = k; r.data_byte = d;
      r.int_value = v; r.error_code = e; r.last = 1'b0;
      return r;
   endfunction

   // next-state and beat generation
   always_comb begin
      phase_in = phase_ff; kind_in = kind_ff; cr_in = cr_ff; acc_in = acc_ff;
      minus_in = minus_ff; digits_in = digits_ff; fault_in = fault_ff;
      left_in = left_ff;
      num_fault = fault_ff;
      n_beats = 2'd0;
      b0 = mk(EV_TEXT, KIND_STATUS, 8'd0, 64'd0, ERR_NONE);
      b1 = b0;
      case (phase_ff)
         PH_IDLE: begin
            if (byte_data == CH_PLUS || byte_data == CH_MINUS) begin
               phase_in = PH_TEXT;
               kind_in  = (byte_data == CH_PLUS) ? KIND_STATUS : KIND_ERRTXT;
               cr_in    = 1'b0;
            end else if (byte_data == CH_CR) begin
               phase_in = PH_LEAD; kind_in = KIND_STATUS; cr_in = 1'b1;
            end else begin
               phase_in = PH_NUM; acc_in = '0; minus_in = 1'b0;
               digits_in = 1'b0; cr_in = 1'b0;
               if (byte_data == CH_COLON) begin
                  kind_in = KIND_INT; fault_in = ERR_NONE;
               end else if (byte_data == CH_DOLLAR) begin
                  kind_in = KIND_BULK; fault_in = ERR_NONE;
               end else begin
                  kind_in = KIND_STATUS; fault_in = ERR_TYPE;
               end
            end
         end
         PH_LEAD: begin
            if (byte_data == CH_LF) begin
               phase_in = PH_IDLE; cr_in = 1'b0; n_beats = 2'd1;
               b0 = mk(EV_ERROR, KIND_STATUS, 8'd0, 64'd0, ERR_EMPTY);
            end else begin
               phase_in = PH_NUM; kind_in = KIND_STATUS; acc_in = '0;
               minus_in = 1'b0; digits_in = 1'b0; fault_in = ERR_TYPE;
               cr_in = (byte_data == CH_CR);
            end
         end
         PH_TEXT: begin
            if (cr_ff && byte_data == CH_LF) begin
               phase_in = PH_IDLE; cr_in = 1'b0; n_beats = 2'd1;
               b0 = mk(EV_DONE, kind_ff, 8'd0, 64'd0, ERR_NONE);
            end else begin
               // held CR goes out ahead of this byte
               cr_in = (byte_data == CH_CR);
               if (cr_ff) begin
                  b0 = mk(EV_TEXT, kind_ff, CH_CR, 64'd0, ERR_NONE);
                  if (byte_data != CH_CR) begin
                     b1 = mk(EV_TEXT, kind_ff, byte_data, 64'd0, ERR_NONE);
                     n_beats = 2'd2;
                  end else begin
                     n_beats = 2'd1;
                  end
               end else if (byte_data != CH_CR) begin
                  b0 = mk(EV_TEXT, kind_ff, byte_data, 64'd0, ERR_NONE);
                  n_beats = 2'd1;
               end
            end
         end
         PH_NUM: begin
            if (cr_ff && byte_data == CH_LF) begin
               phase_in = PH_IDLE; cr_in = 1'b0; n_beats = 2'd1;
               if (fault_ff != ERR_NONE || !digits_ff) begin
                  b0 = mk(EV_ERROR, kind_ff, 8'd0, 64'd0,
                          (fault_ff != ERR_NONE) ? fault_ff : ERR_NUMBER);
               end else if (kind_ff == KIND_INT) begin
                  b0 = mk(EV_DONE, KIND_INT, 8'd0,
                          minus_ff ? (~acc_ff + 64'd1) : acc_ff, ERR_NONE);
               end else if (minus_ff && acc_ff != 64'd0) begin
                  if (acc_ff == 64'd1)
                     b0 = mk(EV_DONE, KIND_NULL, 8'd0, 64'd0, ERR_NONE);
                  else
                     b0 = mk(EV_ERROR, KIND_BULK, 8'd0, 64'd0, ERR_NEGLEN);
               end else if (acc_ff > {33'd0, max_ff}) begin
                  b0 = mk(EV_ERROR, KIND_BULK, 8'd0, 64'd0, ERR_TOOLONG);
               end else begin
                  n_beats = 2'd0;
                  left_in = acc_ff[31:0] + 32'd2;
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               num_fault = (cr_ff && fault_ff == ERR_NONE) ? ERR_NUMBER : fault_ff;
               fault_in = num_fault;
               if (byte_data == CH_CR) begin
                  cr_in = 1'b1;
               end else begin
                  cr_in = 1'b0;
                  if (num_fault == ERR_NONE) begin
                     if (byte_data == CH_MINUS && !minus_ff && !digits_ff)
                        minus_in = 1'b1;
                     else if (!is_digit || ovf)
                        fault_in = ERR_NUMBER;
                     else begin
                        acc_in = acc_next; digits_in = 1'b1;
                     end
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            if (left_ff > 32'd2) begin
               n_beats = 2'd1; left_in = left_ff - 32'd1;
               b0 = mk(EV_PAYLOAD, KIND_BULK, byte_data, 64'd0, ERR_NONE);
            end else if (left_ff <= 32'd1) begin
               left_in = 32'd0; phase_in = PH_IDLE; n_beats = 2'd1;
               b0 = mk(EV_DONE, KIND_BULK, 8'd0, 64'd0, ERR_NONE);
            end else begin
               left_in = left_ff - 32'd1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (n_beats == 2'd2) b1.last = 1'b1;
      else                 b0.last = 1'b1;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; kind_ff <= '0; cr_ff <= 1'b0; acc_ff <= '0;
         minus_ff <= 1'b0; digits_ff <= 1'b0; fault_ff <= '0; left_ff <= '0;
         max_ff <= MAX_BULK_RESET;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         if (byte_valid) begin
            phase_ff <= phase_in; kind_ff <= kind_in; cr_ff <= cr_in;
            acc_ff <= acc_in; minus_ff <= minus_in; digits_ff <= digits_in;
            fault_ff <= fault_in; left_ff <= left_in;
         end
      end
   end

   assign work_valid  = byte_valid && (n_beats != 2'd0);
   assign work.two    = (n_beats == 2'd2);
   assign work.first  = b0;
   assign work.second = b1;

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != 32'd0)
      else $error("payload phase with zero count");
   a_text_no_fault: assert property (@(posedge clock) disable iff (reset)
      work_valid && work.two |-> phase_ff == PH_TEXT)
      else $error("two beats outside text");
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NUM && kind_ff == KIND_BULK |-> acc_ff[63:32] == 32'd0)
      else $error("bulk length out of range");

endmodule

// File: hdl/rrp_back.sv
// ----------------------------------------------------------------------------
// rrp_back: descriptor queue and beat sequencer
// Four-entry queue of descriptors; drains one or two beats per entry.
// ----------------------------------------------------------------------------
module rrp_back import rrp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work,
   output logic     full,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp
);

   localparam int DEPTH = 4;

   work_type   q_ff [DEPTH];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       half_ff;
   logic       pop, push, beat;
   work_type   head;

   assign head      = q_ff[rd_ff];
   // stall the front when it might overrun (one entry slack for the
   // registered full flag path)
   assign full      = (cnt_ff >= 3'(DEPTH - 1));
   assign push      = work_valid;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp       = half_ff ? head.second : head.first;
   assign beat      = rsp_valid && !rsp_stall;
   assign pop       = beat && (!head.two || half_ff);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 3'd1;
      else if (!push && pop) cnt_in = cnt_ff - 3'd1;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= work;
   end

   // pointers and beat half
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) begin
            rd_ff <= rd_ff + 2'd1; half_ff <= 1'b0;
         end else if (beat) begin
            half_ff <= 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff != 3'(DEPTH))
      else $error("queue overflow");
   a_half_two: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> rsp_valid && head.two)
      else $error("second beat without pair");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      pop |-> rsp.last)
      else $error("entry retired without last");

endmodule
